// ===== hdl/bole_pkg.sv =====
// Shared types and codes for the bounded ordered list engine.
package bole_pkg;

  typedef enum logic [2:0] {
    OP_APPEND    = 3'd0,
    OP_PREPEND   = 3'd1,
    OP_INS_AFTER = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_KEY   = 3'd4,
    OP_DEL_BACK  = 3'd5,
    OP_LIST      = 3'd6,
    OP_NONE      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CC_HOLD      = 3'd0,
    CC_APPEND    = 3'd1,
    CC_PREPEND   = 3'd2,
    CC_INS_AFTER = 3'd3,
    CC_DEL_FRONT = 3'd4,
    CC_DEL_KEY   = 3'd5,
    CC_ROTATE    = 3'd6
  } cell_cmd_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] value;
    logic signed [31:0] key;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] entry_value;
    logic [4:0]         entry_count;
    logic               last;
  } out_item_t;

  // broadcast to every cell
  typedef struct packed {
    cell_cmd_e          cmd;
    logic signed [31:0] value;
    logic signed [31:0] key;
    logic signed [31:0] head;
  } cell_ctl_t;

  // key search chain, passed from a cell to the one behind it
  typedef struct packed {
    logic seen;
    logic first;
  } link_t;

endpackage

// ===== hdl/bole_cell.sv =====
// One list position: holds an entry, compares it with the key, shifts with its neighbours.
module bole_cell (
  input  logic                clk_i,
  input  bole_pkg::cell_ctl_t ctl_i,
  input  logic signed [31:0]  left_i,
  input  logic signed [31:0]  right_i,
  input  bole_pkg::link_t     link_i,
  input  logic                valid_i,
  input  logic                at_tail_i,
  input  logic                at_slot_i,
  output logic signed [31:0]  val_o,
  output bole_pkg::link_t     link_o
);

  logic signed [31:0] val_q, val_d;
  logic               match;

  assign match        = valid_i && (val_q == ctl_i.key);
  assign link_o.seen  = link_i.seen | match;
  assign link_o.first = match & ~link_i.seen;
  assign val_o        = val_q;

  always_comb begin
    val_d = val_q;
    unique case (ctl_i.cmd)
      bole_pkg::CC_HOLD:      val_d = val_q;
      bole_pkg::CC_APPEND:    if (at_slot_i) val_d = ctl_i.value;
      bole_pkg::CC_PREPEND:   val_d = left_i;
      bole_pkg::CC_INS_AFTER: begin
        if (link_i.first) begin
          val_d = ctl_i.value;
        end else if (link_i.seen) begin
          val_d = left_i;
        end
      end
      bole_pkg::CC_DEL_FRONT: val_d = right_i;
      bole_pkg::CC_DEL_KEY:   if (link_i.seen || match) val_d = right_i;
      bole_pkg::CC_ROTATE:    val_d = at_tail_i ? ctl_i.head : right_i;
      default:                val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== hdl/bounded_ordered_list_engine.sv =====
// Top level of the bounded ordered list engine: command sequencing over a row of list cells.
//
//   channel   direction  ports                         transfer when
//   command   in         start, busy, cmd_i            start high and busy low at a clock edge
//   result    out        result_valid_o, result_o      result_valid_o high at a clock edge
//
// An update registers the command, then in S_EXEC every cell compares and, where the
// command calls for it, shifts in parallel; its single result follows in the next cycle.
// List-all gives one result per cycle, entry_count results in all, by rotating the row.
// busy is high from the transfer until the last result is on the ports.
// Reset empties the list; entries need no clearing. Results cannot be held off.
module bounded_ordered_list_engine #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bole_pkg::in_item_t  cmd_i,
  output logic                result_valid_o,
  output bole_pkg::out_item_t result_o
);

  localparam int CW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LIST = 3'b100
  } state_e;

  state_e              state_q, state_d;
  bole_pkg::op_e       op_q;
  logic signed [31:0]  value_q, key_q;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q, idx_d;
  bole_pkg::out_item_t res_q, res_d;
  logic                res_valid_q, res_valid_d;
  bole_pkg::cell_ctl_t ctl;
  logic                accept;
  logic                found;
  logic                empty, full;
  logic                list_last;
  logic [CW+4:0]       cnt_d_ext, cnt_q_ext;

  logic signed [31:0]  vals  [LIST_DEPTH];
  bole_pkg::link_t     links [LIST_DEPTH+1];
  logic [LIST_DEPTH-1:0] valid, at_tail, at_slot;

  assign accept         = start && (state_q == S_IDLE);
  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  assign empty     = (count_q == '0);
  assign full      = (count_q == CW'(LIST_DEPTH));
  assign found     = links[LIST_DEPTH].seen;
  assign list_last = (idx_q == count_q - CW'(1));
  assign cnt_d_ext = {5'b0, count_d};
  assign cnt_q_ext = {5'b0, count_q};

  assign links[0] = '0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [31:0] left_v, right_v;

    assign valid[i]   = (CW'(i) < count_q);
    assign at_tail[i] = (count_q == CW'(i + 1));
    assign at_slot[i] = (count_q == CW'(i));

    if (i == 0) begin : g_first
      assign left_v = ctl.value;
    end else begin : g_mid
      assign left_v = vals[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_end
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = vals[i+1];
    end

    bole_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .left_i    (left_v),
      .right_i   (right_v),
      .link_i    (links[i]),
      .valid_i   (valid[i]),
      .at_tail_i (at_tail[i]),
      .at_slot_i (at_slot[i]),
      .val_o     (vals[i]),
      .link_o    (links[i+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    ctl.cmd     = bole_pkg::CC_HOLD;
    ctl.value   = value_q;
    ctl.key     = key_q;
    ctl.head    = vals[0];

    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d           = S_IDLE;
        res_valid_d       = 1'b1;
        res_d.status      = bole_pkg::ST_OK;
        res_d.entry_value = '0;
        res_d.last        = 1'b1;
        unique case (op_q)
          bole_pkg::OP_APPEND: begin
            if (full) begin
              res_d.status = bole_pkg::ST_FULL;
            end else begin
              ctl.cmd = bole_pkg::CC_APPEND;
              count_d = count_q + CW'(1);
            end
          end
          bole_pkg::OP_PREPEND: begin
            if (full) begin
              res_d.status = bole_pkg::ST_FULL;
            end else begin
              ctl.cmd = bole_pkg::CC_PREPEND;
              count_d = count_q + CW'(1);
            end
          end
          bole_pkg::OP_INS_AFTER: begin
            if (empty) begin
              res_d.status = bole_pkg::ST_EMPTY;
            end else if (full) begin
              res_d.status = bole_pkg::ST_FULL;
            end else begin
              ctl.cmd = bole_pkg::CC_INS_AFTER;
              if (found) count_d = count_q + CW'(1);
              else       res_d.status = bole_pkg::ST_NOTFOUND;
            end
          end
          bole_pkg::OP_DEL_FRONT: begin
            if (empty) begin
              res_d.status = bole_pkg::ST_EMPTY;
            end else begin
              ctl.cmd = bole_pkg::CC_DEL_FRONT;
              count_d = count_q - CW'(1);
            end
          end
          bole_pkg::OP_DEL_KEY: begin
            if (empty) begin
              res_d.status = bole_pkg::ST_EMPTY;
            end else begin
              ctl.cmd = bole_pkg::CC_DEL_KEY;
              if (found) count_d = count_q - CW'(1);
              else       res_d.status = bole_pkg::ST_NOTFOUND;
            end
          end
          bole_pkg::OP_DEL_BACK: begin
            if (empty) res_d.status = bole_pkg::ST_EMPTY;
            else       count_d = count_q - CW'(1);
          end
          bole_pkg::OP_LIST: begin
            if (empty) begin
              res_d.status = bole_pkg::ST_EMPTY;
            end else begin
              res_valid_d = 1'b0;
              idx_d       = '0;
              state_d     = S_LIST;
            end
          end
          default: ;
        endcase
        res_d.entry_count = cnt_d_ext[4:0];
      end
      S_LIST: begin
        ctl.cmd           = bole_pkg::CC_ROTATE;
        res_valid_d       = 1'b1;
        res_d.status      = bole_pkg::ST_OK;
        res_d.entry_value = vals[0];
        res_d.entry_count = cnt_q_ext[4:0];
        res_d.last        = list_last;
        idx_d             = idx_q + CW'(1);
        if (list_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      op_q    <= cmd_i.operation;
      value_q <= cmd_i.value;
      key_q   <= cmd_i.key;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(LIST_DEPTH))
    else $error("entry count beyond depth");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted command not executed");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.last) |-> state_q == S_IDLE)
    else $error("final result while still busy");

  a_more_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.last) |-> state_q == S_LIST)
    else $error("non-final result outside listing");

endmodule

// ===== verif/bole_checker.sv =====
// Checker for the list engine: tracks the list from accepted commands and compares each result.
module bole_checker
  import bole_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      busy_i,
  input  in_item_t  cmd_i,
  input  logic      res_valid_i,
  input  out_item_t res_i,
  output int        fail_count_o,
  output int        outstanding_o,
  output int        results_seen_o,
  output int        full_seen_o
);

  logic signed [31:0] slots [DEPTH];
  int                 fill    = 0;
  int                 fails   = 0;
  int                 pending = 0;
  int                 results = 0;
  int                 fulls   = 0;
  out_item_t          expected_q [$];

  assign fail_count_o   = fails;
  assign outstanding_o  = pending;
  assign results_seen_o = results;
  assign full_seen_o    = fulls;

  function automatic int find_slot(logic signed [31:0] k);
    for (int i = 0; i < fill; i++) begin
      if (slots[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void put_slot(int pos, logic signed [31:0] v);
    for (int i = fill; i > pos; i--) slots[i] = slots[i - 1];
    slots[pos] = v;
    fill++;
  endfunction

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < fill; i++) slots[i] = slots[i + 1];
    fill--;
  endfunction

  function automatic void field_error(string field, longint want, longint got);
    fails++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  task automatic apply_command(input in_item_t c);
    status_e st;
    int      pos;
    st = ST_OK;
    case (c.operation)
      OP_APPEND, OP_PREPEND: begin
        if (fill >= DEPTH) st = ST_FULL;
        else put_slot((c.operation == OP_APPEND) ? fill : 0, c.value);
      end
      OP_INS_AFTER: begin
        if (fill == 0) st = ST_EMPTY;
        else if (fill >= DEPTH) st = ST_FULL;
        else begin
          pos = find_slot(c.key);
          if (pos < 0) st = ST_NOTFOUND;
          else put_slot(pos + 1, c.value);
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (fill == 0) st = ST_EMPTY;
        else drop_slot((c.operation == OP_DEL_FRONT) ? 0 : fill - 1);
      end
      OP_DEL_KEY: begin
        if (fill == 0) st = ST_EMPTY;
        else begin
          pos = find_slot(c.key);
          if (pos < 0) st = ST_NOTFOUND;
          else drop_slot(pos);
        end
      end
      OP_LIST: begin
        if (fill == 0) st = ST_EMPTY;
        else begin
          for (int i = 0; i < fill; i++)
            expected_q.push_back(out_item_t'{ST_OK, slots[i], 5'(fill), i == fill - 1});
          return;
        end
      end
      default: ;
    endcase
    if (st == ST_FULL) fulls++;
    expected_q.push_back(out_item_t'{st, 32'sd0, 5'(fill), 1'b1});
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      fails++;
      $display("%0t: expected no result, actual status=%0d value=%0d count=%0d last=%0b",
               $time, got.status, got.entry_value, got.entry_count, got.last);
      return;
    end
    want = expected_q.pop_front();
    results++;
    if (got.status !== want.status) field_error("status", want.status, got.status);
    if (got.entry_value !== want.entry_value)
      field_error("entry_value", want.entry_value, got.entry_value);
    if (got.entry_count !== want.entry_count)
      field_error("entry_count", want.entry_count, got.entry_count);
    if (got.last !== want.last) field_error("last", want.last, got.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill = 0;
      expected_q.delete();
    end else begin
      if (res_valid_i === 1'b1) check_result(res_i);
      else if (res_valid_i !== 1'b0) begin
        fails++;
        $display("%0t: result strobe unknown, expected 0 or 1, actual %b", $time, res_valid_i);
      end
      if (start_i === 1'b1 && busy_i === 1'b0) apply_command(cmd_i);
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the list engine: command stimulus, pacing, watchdog and verdict.
module tb_top;
  import bole_pkg::*;

  localparam int DEPTH     = 16;
  localparam int QUIET_MAX = 2000;
  localparam int PER_PHASE = 63;
  localparam int BURST     = 32;
  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  in_item_t  cmd_i  = '0;
  logic      busy;
  logic      result_valid_o;
  out_item_t result_o;

  int fail_count;
  int outstanding;
  int results_seen;
  int full_seen;
  int idle_pct = 28;
  int issued   = 0;
  int quiet    = 0;

  // small set of values so that keys often hit, extremes among them
  logic signed [31:0] pool [8] = '{MINV, MAXV, 32'sd0, -32'sd1, 32'sd1, 32'sd7,
                                   32'sh5555_5555, 32'shaaaa_aaaa};

  bounded_ordered_list_engine #(.LIST_DEPTH(DEPTH)) dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .cmd_i,
    .result_valid_o,
    .result_o
  );

  bole_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i,
    .rst_ni,
    .start_i       (start),
    .busy_i        (busy),
    .cmd_i,
    .res_valid_i   (result_valid_o),
    .res_i         (result_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .results_seen_o(results_seen),
    .full_seen_o   (full_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) quiet = 0;
      else begin
        quiet++;
        if (quiet >= QUIET_MAX) begin
          $display("%0t: no transfer for %0d cycles", $time, QUIET_MAX);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  function automatic in_item_t mk(op_e op, logic signed [31:0] v, logic signed [31:0] k);
    in_item_t c;
    c.operation = op;
    c.value     = v;
    c.key       = k;
    return c;
  endfunction

  function automatic logic signed [31:0] any_word();
    if ($urandom_range(3) == 0) return $urandom;
    return pool[$urandom_range(7)];
  endfunction

  function automatic in_item_t rand_cmd(bit grow);
    int  r;
    op_e op;
    r = $urandom_range(99);
    if (r < 5) op = OP_NONE;
    else if (r < 15) op = OP_LIST;
    else if ((r < 85) == grow) op = op_e'($urandom_range(2));
    else op = op_e'(3 + $urandom_range(2));
    return mk(op, any_word(), any_word());
  endfunction

  task automatic issue(input in_item_t c);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
    issued++;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      cmd_i <= mk(op_e'($urandom_range(7)), $urandom, $urandom);
      @(posedge clk_i);
    end
  endtask

  initial begin
    bit grow;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, unused code
    issue(mk(OP_LIST, 32'sd0, 32'sd0));
    issue(mk(OP_INS_AFTER, 32'sd1, 32'sd1));
    issue(mk(OP_DEL_FRONT, 32'sd0, 32'sd0));
    issue(mk(OP_DEL_KEY, 32'sd0, MINV));
    issue(mk(OP_DEL_BACK, 32'sd0, 32'sd0));
    issue(mk(OP_NONE, -32'sd1, -32'sd1));
    // single entry, missing key, then delete it by key
    issue(mk(OP_APPEND, MAXV, 32'sd0));
    issue(mk(OP_INS_AFTER, 32'sd0, MINV));
    issue(mk(OP_DEL_KEY, 32'sd0, MAXV));
    // fill to depth, with duplicates
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) issue(mk(OP_PREPEND, MINV, 32'sd0));
      else if (i == 1) issue(mk(OP_INS_AFTER, -32'sd1, MINV));
      else issue(mk(OP_APPEND, i[0] ? MAXV : 32'(i), 32'sd0));
    end
    issue(mk(OP_APPEND, 32'sd5, 32'sd0));
    issue(mk(OP_PREPEND, 32'sd5, 32'sd0));
    issue(mk(OP_INS_AFTER, 32'sd5, MAXV));
    issue(mk(OP_LIST, 32'sd0, 32'sd0));
    // key at the head, missing key, back
    issue(mk(OP_DEL_KEY, 32'sd0, MINV));
    issue(mk(OP_DEL_KEY, 32'sd0, 32'sd12345));
    issue(mk(OP_DEL_BACK, 32'sd0, 32'sd0));

    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 28 : (p == 1) ? 70 : 0;
      for (int n = 0; n < PER_PHASE; n++) begin
        grow = ((issued / BURST) % 2 == 1);
        issue(rand_cmd(grow));
      end
    end

    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Issued %0d commands: directed cases, then random fill and drain bursts", issued);
    $display("under 28%%, 70%% and no sender idling; %0d results checked, %0d full refusals.",
             results_seen, full_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
